FILE: hw/rtl/max_flow_edmonds_karp_unit_macros.svh
// Assertion macros for the max-flow unit checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MAX_FLOW_EDMONDS_KARP_UNIT_MACROS_SVH
`define MAX_FLOW_EDMONDS_KARP_UNIT_MACROS_SVH

// same-cycle implication
`define MFEK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mfek assertion failed");

// next-cycle implication
`define MFEK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mfek assertion failed");

`endif

FILE: hw/rtl/mfek_pkg.sv
// Shared types and constants of the max-flow unit.
// No dependencies.
package mfek_pkg;

  localparam int unsigned MAX_NODES_DEF = 64;
  localparam int unsigned CAP_WIDTH_DEF = 16;
  localparam int unsigned NODE_W        = 6;
  localparam int unsigned CAP_IN_W      = 16;
  localparam int unsigned FLOW_W        = 22;
  localparam int unsigned NCNT_W        = 7;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 7;

  typedef enum logic [0:0] {
    CMD_ADD_EDGE = 1'b0,
    CMD_SOLVE    = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_SOURCE     = 2'd1,
    CFG_SINK       = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_START,
    ST_POP,
    ST_SCAN,
    ST_BN_RD,
    ST_BN_CHK,
    ST_AUG_RD,
    ST_AUG_SUB,
    ST_AUG_ADD,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/mfek_req_if.sv
// Request channel of the max-flow unit: edge additions and solve commands.
// Depends on mfek_pkg.
interface mfek_req_if import mfek_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [NODE_W-1:0]   from_node;
  logic [NODE_W-1:0]   to_node;
  logic [CAP_IN_W-1:0] edge_capacity;

  modport source (output valid, command, from_node, to_node, edge_capacity, input ready);
  modport sink (input valid, command, from_node, to_node, edge_capacity, output ready);
endinterface

FILE: hw/rtl/mfek_rsp_if.sv
// Response channel of the max-flow unit: the total flow of a solve.
// Depends on mfek_pkg.
interface mfek_rsp_if import mfek_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] max_flow;

  modport source (output valid, max_flow, input ready);
  modport sink (input valid, max_flow, output ready);
endinterface

FILE: hw/rtl/mfek_matrix_ram.sv
// Residual matrix store: one write port, one read port, registered read data.
// No dependencies.
module mfek_matrix_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 18
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/max_flow_edmonds_karp_unit.sv
// Max-flow unit (Edmonds-Karp) over an adjacency matrix in one synchronous RAM.
// Add-edge requests: one per cycle while idle, read then registered write, with forwarding.
// Solve: a search scans the matrix row of each dequeued node; the path is walked back for the
// bottleneck and again to push flow, paced by the RAM port. Result, then a clear pass follows.
// Reset and every solve end in a clear pass over all 2^(2*clog2(MAX_NODES)) matrix entries
// (4096 at 64 nodes) with input stalled; configuration writes are taken at any time.
module max_flow_edmonds_karp_unit import mfek_pkg::*; #(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  parameter int unsigned CAP_WIDTH = CAP_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mfek_req_if.sink              req_i,
  mfek_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned AW   = 2 * NW;
  localparam int unsigned MW   = CAP_WIDTH + 2;
  localparam int unsigned CW0  = $clog2(MAX_NODES + 1);
  localparam int unsigned CW   = (CW0 > NCNT_W) ? CW0 : NCNT_W;
  localparam int unsigned SW   = ((CAP_WIDTH > CAP_IN_W) ? CAP_WIDTH : CAP_IN_W) + 2;
  localparam int unsigned TW   = (MW > FLOW_W) ? MW : FLOW_W;
  localparam logic [SW-1:0] CAP_MAX_S = SW'((64'd1 << CAP_WIDTH) - 64'd1);
  localparam logic [CW-1:0] MAX_N     = CW'(MAX_NODES);

  state_e state_q, state_d;

  logic [NCNT_W-1:0] node_count_q;
  logic [NODE_W-1:0] src_q, snk_q;

  logic [AW-1:0] clr_q, clr_d;
  logic          add_pend_q, add_pend_d;
  logic [AW-1:0] add_addr_q, add_addr_d;
  logic [SW-1:0] add_cap_q, add_cap_d;
  logic          lw_valid_q, lw_valid_d;
  logic [AW-1:0] lw_addr_q, lw_addr_d;
  logic [MW-1:0] lw_data_q, lw_data_d;

  logic [NW-1:0] u_q, u_d;
  logic [CW-1:0] v_q, v_d;
  logic          pend_q, pend_d;
  logic [NW-1:0] pv_q, pv_d;
  logic [CW-1:0] head_q, head_d;
  logic [CW-1:0] tail_q, tail_d;
  logic [NW-1:0] w_q, w_d;
  logic [MW-1:0] bn_q, bn_d;
  logic [FLOW_W-1:0] total_q, total_d;
  logic              out_valid_q, out_valid_d;
  logic [FLOW_W-1:0] out_data_q, out_data_d;

  logic [MAX_NODES-1:0] visited_q;
  logic [NW-1:0]        parent_q [MAX_NODES];
  logic [NW-1:0]        queue_q  [MAX_NODES];
  logic [NW-1:0]        par_rd_q, q_rd_q;

  logic          vis_clr, vis_set;
  logic [NW-1:0] vis_idx;
  logic          par_we;
  logic [NW-1:0] par_idx, par_val;
  logic          q_we;
  logic [NW-1:0] q_idx, q_val;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0] n_use;
  logic [NW-1:0] s_nw, t_nw, par_w;
  logic [MW-1:0] add_base, add_sum;
  logic [SW-1:0] add_sumx, cap_clamp;
  logic [TW-1:0] tsum;
  logic          req_ready;

  mfek_matrix_ram #(
    .ADDR_W(AW),
    .DATA_W(MW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign n_use = (CW'(node_count_q) > MAX_N) ? MAX_N : CW'(node_count_q);
  assign s_nw  = NW'(src_q);
  assign t_nw  = NW'(snk_q);
  assign par_w = par_rd_q;

  assign cap_clamp = (SW'(req_i.edge_capacity) > CAP_MAX_S) ? CAP_MAX_S
                                                            : SW'(req_i.edge_capacity);
  assign add_base  = (lw_valid_q && (lw_addr_q == add_addr_q)) ? lw_data_q : mem_rdata;
  assign add_sumx  = SW'(add_base) + add_cap_q;
  assign add_sum   = (add_sumx > CAP_MAX_S) ? MW'(CAP_MAX_S) : MW'(add_sumx);
  assign tsum      = TW'(total_q) + TW'(bn_q);

  assign req_i.ready    = req_ready;
  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.max_flow = out_data_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    add_pend_d  = 1'b0;
    add_addr_d  = add_addr_q;
    add_cap_d   = add_cap_q;
    lw_valid_d  = 1'b0;
    lw_addr_d   = lw_addr_q;
    lw_data_d   = lw_data_q;
    u_d         = u_q;
    v_d         = v_q;
    pend_d      = pend_q;
    pv_d        = pv_q;
    head_d      = head_q;
    tail_d      = tail_q;
    w_d         = w_q;
    bn_d        = bn_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    vis_clr     = 1'b0;
    vis_set     = 1'b0;
    vis_idx     = '0;
    par_we      = 1'b0;
    par_idx     = '0;
    par_val     = '0;
    q_we        = 1'b0;
    q_idx       = '0;
    q_val       = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    req_ready   = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (add_pend_q) begin
      mem_we     = 1'b1;
      mem_waddr  = add_addr_q;
      mem_wdata  = add_sum;
      lw_valid_d = 1'b1;
      lw_addr_d  = add_addr_q;
      lw_data_d  = add_sum;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.command == CMD_SOLVE) begin
            state_d = ST_INIT;
          end else if ((CW'(req_i.from_node) < n_use) && (CW'(req_i.to_node) < n_use)) begin
            add_pend_d = 1'b1;
            add_addr_d = {NW'(req_i.from_node), NW'(req_i.to_node)};
            add_cap_d  = cap_clamp;
            mem_raddr  = {NW'(req_i.from_node), NW'(req_i.to_node)};
          end
        end
      end
      ST_INIT: begin
        total_d = '0;
        if ((CW'(src_q) >= n_use) || (CW'(snk_q) >= n_use) || (src_q == snk_q)) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        vis_clr = 1'b1;
        vis_set = 1'b1;
        vis_idx = s_nw;
        q_we    = 1'b1;
        q_idx   = '0;
        q_val   = s_nw;
        par_we  = 1'b1;
        par_idx = s_nw;
        par_val = s_nw;
        head_d  = '0;
        tail_d  = CW'(1);
        state_d = ST_POP;
      end
      ST_POP: begin
        if ((head_q < tail_q) && (head_q < MAX_N)) begin
          u_d     = q_rd_q;
          head_d  = head_q + CW'(1);
          v_d     = '0;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        pend_d = 1'b0;
        if (v_q < n_use) begin
          mem_raddr = {u_q, v_q[NW-1:0]};
          v_d       = v_q + CW'(1);
          pend_d    = 1'b1;
          pv_d      = v_q[NW-1:0];
        end
        if (pend_q && !visited_q[pv_q] && (mem_rdata != '0)) begin
          vis_set = 1'b1;
          vis_idx = pv_q;
          par_we  = 1'b1;
          par_idx = pv_q;
          par_val = u_q;
          if (tail_q < MAX_N) begin
            q_we   = 1'b1;
            q_idx  = tail_q[NW-1:0];
            q_val  = pv_q;
            tail_d = tail_q + CW'(1);
          end
          if (pv_q == t_nw) begin
            state_d = ST_BN_RD;
            w_d     = pv_q;
            bn_d    = '1;
            pend_d  = 1'b0;
          end
        end
        if (!pend_q && (v_q >= n_use)) begin
          state_d = ST_POP;
        end
      end
      ST_BN_RD: begin
        if (w_q == s_nw) begin
          w_d     = t_nw;
          state_d = ST_AUG_RD;
        end else begin
          mem_raddr = {par_w, w_q};
          state_d   = ST_BN_CHK;
        end
      end
      ST_BN_CHK: begin
        if (mem_rdata < bn_q) begin
          bn_d = mem_rdata;
        end
        w_d     = par_w;
        state_d = ST_BN_RD;
      end
      ST_AUG_RD: begin
        if (w_q == s_nw) begin
          total_d = tsum[FLOW_W-1:0];
          state_d = ST_START;
        end else begin
          mem_raddr = {par_w, w_q};
          state_d   = ST_AUG_SUB;
        end
      end
      ST_AUG_SUB: begin
        mem_we    = 1'b1;
        mem_waddr = {par_w, w_q};
        mem_wdata = mem_rdata - bn_q;
        mem_raddr = {w_q, par_w};
        state_d   = ST_AUG_ADD;
      end
      ST_AUG_ADD: begin
        mem_we    = 1'b1;
        mem_waddr = {w_q, par_w};
        mem_wdata = mem_rdata + bn_q;
        w_d       = par_w;
        state_d   = ST_AUG_RD;
      end
      ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = total_q;
          clr_d       = '0;
          state_d     = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      add_pend_q   <= 1'b0;
      lw_valid_q   <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      visited_q    <= '0;
      node_count_q <= NCNT_W'(64);
      src_q        <= NODE_W'(0);
      snk_q        <= NODE_W'(1);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      add_pend_q  <= add_pend_d;
      lw_valid_q  <= lw_valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      visited_q   <= (vis_clr ? '0 : visited_q) |
                     (vis_set ? (MAX_NODES'(1) << vis_idx) : '0);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NODE_COUNT: node_count_q <= cfg_data_i[NCNT_W-1:0];
          CFG_SOURCE:     src_q        <= cfg_data_i[NODE_W-1:0];
          CFG_SINK:       snk_q        <= cfg_data_i[NODE_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    add_addr_q <= add_addr_d;
    add_cap_q  <= add_cap_d;
    lw_addr_q  <= lw_addr_d;
    lw_data_q  <= lw_data_d;
    u_q        <= u_d;
    v_q        <= v_d;
    pv_q       <= pv_d;
    head_q     <= head_d;
    tail_q     <= tail_d;
    w_q        <= w_d;
    bn_q       <= bn_d;
    total_q    <= total_d;
    out_data_q <= out_data_d;
    if (par_we) begin
      parent_q[par_idx] <= par_val;
    end
    if (q_we) begin
      queue_q[q_idx] <= q_val;
    end
    par_rd_q <= (par_we && (par_idx == w_d)) ? par_val : parent_q[w_d];
    q_rd_q   <= (q_we && (q_idx == head_d[NW-1:0])) ? q_val : queue_q[head_d[NW-1:0]];
  end

endmodule

FILE: hw/rtl/mfek_checker.sv
// Port-level checks of the max-flow unit, bound to the top level.
// Depends on mfek_pkg and max_flow_edmonds_karp_unit_macros.svh.
`include "max_flow_edmonds_karp_unit_macros.svh"

module mfek_checker import mfek_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              req_command_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [FLOW_W-1:0] rsp_max_flow_i
);

  `MFEK_ASSERT_NEXT(a_solve_stalls, req_valid_i && req_ready_i && (req_command_i == CMD_SOLVE), !req_ready_i)
  `MFEK_ASSERT_IMPL(a_rsp_in_solve, $rose(rsp_valid_i), !req_ready_i)
  `MFEK_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `MFEK_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_max_flow_i))

endmodule

bind max_flow_edmonds_karp_unit mfek_checker u_mfek_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_command_i (req_i.command),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_max_flow_i(rsp_o.max_flow)
);

FILE: tb/sv/max_flow_edmonds_karp_unit_tb.sv
`timescale 1ns / 1ps
// Testbench of max_flow_edmonds_karp_unit: fixed and random add-edge graphs, then solves.
// Depends on mfek_pkg, mfek_req_if, mfek_rsp_if and the unit; a class predicts each total flow.

class flow_scoreboard;
  localparam int unsigned Nodes = mfek_pkg::MAX_NODES_DEF;
  localparam int unsigned CapMax = (1 << mfek_pkg::CAP_WIDTH_DEF) - 1;

  int unsigned cap_m[Nodes*Nodes];
  int unsigned prev_node[Nodes];
  bit          seen[Nodes];
  int unsigned bfs_order[Nodes];
  int unsigned node_count;
  int unsigned src_node;
  int unsigned dst_node;
  logic [mfek_pkg::FLOW_W-1:0] flow_q[$];
  int unsigned errors;

  function new();
    foreach (cap_m[i]) cap_m[i] = 0;
    node_count = 64;
    src_node = 0;
    dst_node = 1;
    errors = 0;
  endfunction

  function void note_config(logic [1:0] idx, logic [6:0] data);
    if (idx == mfek_pkg::CFG_NODE_COUNT) node_count = data;
    else if (idx == mfek_pkg::CFG_SOURCE) src_node = data[5:0];
    else if (idx == mfek_pkg::CFG_SINK) dst_node = data[5:0];
  endfunction

  function int unsigned used_nodes();
    return (node_count > Nodes) ? Nodes : node_count;
  endfunction

  function bit find_route(int unsigned n);
    int unsigned head;
    int unsigned tail;
    int unsigned u;
    foreach (seen[i]) seen[i] = 0;
    head = 0;
    tail = 0;
    bfs_order[tail++] = src_node;
    seen[src_node] = 1;
    prev_node[src_node] = src_node;
    while (head < tail && head < Nodes) begin
      u = bfs_order[head++];
      for (int unsigned v = 0; v < n; v++) begin
        if (!seen[v] && cap_m[u*Nodes+v] > 0) begin
          if (tail < Nodes) bfs_order[tail++] = v;
          seen[v] = 1;
          prev_node[v] = u;
          if (v == dst_node) return 1;
        end
      end
    end
    return 0;
  endfunction

  function int unsigned max_flow_of_graph();
    int unsigned n;
    int unsigned total;
    int unsigned bneck;
    int unsigned v;
    int unsigned u;
    int unsigned steps;
    n = used_nodes();
    total = 0;
    if (src_node >= n || dst_node >= n || src_node == dst_node) return 0;
    while (find_route(n)) begin
      bneck = 32'hFFFF_FFFF;
      v = dst_node;
      steps = 0;
      while (v != src_node && steps < n) begin
        u = prev_node[v];
        if (cap_m[u*Nodes+v] < bneck) bneck = cap_m[u*Nodes+v];
        v = u;
        steps++;
      end
      v = dst_node;
      steps = 0;
      while (v != src_node && steps < n) begin
        u = prev_node[v];
        cap_m[u*Nodes+v] -= bneck;
        cap_m[v*Nodes+u] += bneck;
        v = u;
        steps++;
      end
      total += bneck;
    end
    return total;
  endfunction

  function void note_request(mfek_pkg::cmd_e cmd, int unsigned from_n, int unsigned to_n,
                             int unsigned cap);
    int unsigned n;
    int unsigned sum;
    int unsigned flow;
    n = used_nodes();
    if (cmd == mfek_pkg::CMD_ADD_EDGE) begin
      if (from_n < n && to_n < n) begin
        sum = cap_m[from_n*Nodes+to_n] + cap;
        cap_m[from_n*Nodes+to_n] = (sum > CapMax) ? CapMax : sum;
      end
    end else begin
      flow = max_flow_of_graph();
      flow_q.push_back(flow[mfek_pkg::FLOW_W-1:0]);
      foreach (cap_m[i]) cap_m[i] = 0;
    end
  endfunction

  function void check_result(logic [mfek_pkg::FLOW_W-1:0] flow);
    logic [mfek_pkg::FLOW_W-1:0] want;
    if (flow_q.size() == 0) begin
      $error("max_flow: no result expected, got %0d", flow);
      errors++;
      return;
    end
    want = flow_q.pop_front();
    if (flow !== want) begin
      $error("max_flow: expected %0d, actual %0d", want, flow);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return flow_q.size();
  endfunction
endclass

module max_flow_edmonds_karp_unit_tb;
  import mfek_pkg::*;

  localparam int unsigned WatchdogLimit = 400000;
  localparam int unsigned DrainCycles = 4400;
  localparam logic [CFG_IDX_W-1:0] CfgIdxUnused = 2'd3;
  localparam int unsigned ItemTarget = 650;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mfek_req_if req_if ();
  mfek_rsp_if rsp_if ();

  flow_scoreboard sb = new();
  int unsigned idle_mode;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent;
  int unsigned cur_n;
  int unsigned cur_s;
  int unsigned cur_t;

  max_flow_edmonds_karp_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    if ((idle_mode == 2 && $urandom_range(0, 99) < 64) ||
        (idle_mode == 3 && $urandom_range(0, 99) < 36)) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.max_flow);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.note_config(idx, data[6:0]);
    @(posedge clk_i);
  endtask

  task automatic set_graph(int unsigned n, int unsigned s, int unsigned t);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    write_cfg(CFG_NODE_COUNT, n);
    write_cfg(CFG_SOURCE, s);
    write_cfg(CFG_SINK, t);
    cur_n = n;
    cur_s = s;
    cur_t = t;
  endtask

  task automatic send_request(cmd_e cmd, int unsigned from_n, int unsigned to_n,
                              int unsigned cap);
    int unsigned pct;
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.from_node <= from_n[NODE_W-1:0];
    req_if.to_node <= to_n[NODE_W-1:0];
    req_if.edge_capacity <= cap[CAP_IN_W-1:0];
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(cmd, from_n & 63, to_n & 63, cap & 16'hFFFF);
    items_sent++;
    pct = (idle_mode == 1) ? 64 : (idle_mode == 3) ? 36 : 0;
    if ($urandom_range(0, 99) < pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < pct);
    end
  endtask

  task automatic send_random_graph(int unsigned edges);
    int unsigned f;
    int unsigned h;
    int unsigned c;
    int unsigned span;
    span = (cur_n == 0) ? 0 : ((cur_n > 64) ? 63 : cur_n - 1);
    for (int unsigned k = 0; k < edges; k++) begin
      f = ($urandom_range(0, 3) == 0) ? cur_s : $urandom_range(0, span);
      h = ($urandom_range(0, 3) == 0) ? cur_t : $urandom_range(0, span);
      if ($urandom_range(0, 11) == 0) f = $urandom_range(0, 63);
      if ($urandom_range(0, 11) == 0) h = $urandom_range(0, 63);
      case ($urandom_range(0, 7))
        0: c = 16'hFFFF;
        1: c = 0;
        2, 3: c = $urandom_range(0, 16'hFFFF);
        default: c = $urandom_range(1, 50);
      endcase
      send_request(CMD_ADD_EDGE, f, h, c);
    end
    send_request(CMD_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 16'hFFFF));
  endtask

  initial begin
    int unsigned n;
    int unsigned phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NODE_COUNT;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.command = CMD_ADD_EDGE;
    req_if.from_node = '0;
    req_if.to_node = '0;
    req_if.edge_capacity = '0;
    idle_mode = 0;
    items_sent = 0;
    cur_n = 64;
    cur_s = 0;
    cur_t = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(CfgIdxUnused, 7'h7F);
    set_graph(4, 0, 3);
    send_request(CMD_ADD_EDGE, 0, 1, 16'hFFFF);
    send_request(CMD_ADD_EDGE, 0, 1, 16'hFFFF);
    send_request(CMD_ADD_EDGE, 1, 3, 40000);
    send_request(CMD_ADD_EDGE, 1, 3, 40000);
    send_request(CMD_ADD_EDGE, 0, 2, 0);
    send_request(CMD_ADD_EDGE, 2, 2, 500);
    send_request(CMD_ADD_EDGE, 0, 2, 7);
    send_request(CMD_ADD_EDGE, 2, 1, 3);
    send_request(CMD_ADD_EDGE, 63, 3, 100);
    send_request(CMD_ADD_EDGE, 2, 63, 100);
    send_request(CMD_SOLVE, 0, 0, 0);
    send_request(CMD_SOLVE, 63, 63, 16'hFFFF);
    set_graph(64, 63, 0);
    send_request(CMD_ADD_EDGE, 63, 0, 16'hFFFF);
    send_request(CMD_ADD_EDGE, 63, 42, 21);
    send_request(CMD_ADD_EDGE, 42, 0, 16'h5555);
    send_request(CMD_SOLVE, 0, 0, 0);
    set_graph(5, 2, 2);
    send_request(CMD_ADD_EDGE, 2, 3, 9);
    send_request(CMD_SOLVE, 0, 0, 0);
    set_graph(3, 5, 1);
    send_request(CMD_ADD_EDGE, 0, 1, 9);
    send_request(CMD_SOLVE, 0, 0, 0);
    set_graph(0, 0, 0);
    send_request(CMD_ADD_EDGE, 0, 0, 9);
    send_request(CMD_SOLVE, 0, 0, 0);
    set_graph(127, 0, 63);
    send_graph_fixed: begin
      send_request(CMD_ADD_EDGE, 0, 63, 12);
      send_request(CMD_SOLVE, 0, 0, 0);
    end
    set_graph(1, 0, 0);
    send_request(CMD_SOLVE, 0, 0, 0);

    phase = 0;
    while (items_sent < ItemTarget) begin
      idle_mode = phase % 4;
      case (phase % 6)
        0: n = 64;
        1: n = $urandom_range(1, 3);
        default: n = $urandom_range(4, 12);
      endcase
      set_graph(n, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
      if (phase % 5 == 4) set_graph(n, 0, n - 1);
      for (int unsigned g = 0; g < 8 && items_sent < ItemTarget; g++) begin
        send_random_graph((n == 64) ? $urandom_range(4, 24) : $urandom_range(1, 10));
      end
      phase++;
    end
    req_if.valid <= 1'b0;
    idle_mode = 0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mfek_pkg.sv
hw/rtl/mfek_req_if.sv
hw/rtl/mfek_rsp_if.sv
hw/rtl/mfek_matrix_ram.sv
hw/rtl/max_flow_edmonds_karp_unit.sv
hw/rtl/mfek_checker.sv
tb/sv/max_flow_edmonds_karp_unit_tb.sv
